FILE: design/cubic_bezier_stroke_tessellator_top_macros.svh
// assertion helpers for the stroke tessellator
`ifndef CUBIC_BEZIER_STROKE_TESSELLATOR_TOP_MACROS_SVH
`define CUBIC_BEZIER_STROKE_TESSELLATOR_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define CBST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define CBST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/cbst_pkg.sv
`timescale 1ns / 1ps
package cbst_pkg;

  localparam int ACC_W   = 66;
  localparam int MP_W    = 26;
  localparam int CNT_W   = 5;
  localparam int T_ONE   = 65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DIV_WAIT,
    S_MUL,
    S_MUL_WAIT,
    S_SRCH,
    S_EMIT0,
    S_EMIT1
  } state_t;

  typedef enum logic [4:0] {
    OP_U2, OP_B0, OP_C1, OP_T2, OP_B3, OP_C2,
    OP_X0, OP_X1, OP_X2, OP_X3,
    OP_Y0, OP_Y1, OP_Y2, OP_Y3,
    OP_L2X, OP_L2Y,
    OP_NW, OP_NN,
    OP_KL, OP_KK
  } op_t;

  typedef struct packed {
    logic             start;
    logic             clear;
    logic             sgn;
    logic [ACC_W-1:0] mcand;
    logic [MP_W-1:0]  mplier;
    logic [CNT_W-1:0] nbits;
  } mul_req_t;

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    logic [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'h7fff;
    end else if (v < -18'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: design/cbst_mul.sv
`timescale 1ns / 1ps
module cbst_mul import cbst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mul_req_t         req,
  output logic             busy,
  output logic             done,
  output logic [ACC_W-1:0] acc
);

  logic [ACC_W-1:0] mc;
  logic [MP_W-1:0]  mp;
  logic [CNT_W-1:0] cnt;
  logic             sg;
  logic [ACC_W-1:0] addend;

  // top multiplier bit carries negative weight in signed mode
  assign addend = (sg && cnt == CNT_W'(1)) ? (~mc + ACC_W'(1)) : mc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mc <= req.mcand;
      mp <= req.mplier;
      sg <= req.sgn;
      if (req.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mp[0]) begin
        acc <= acc + addend;
      end
      mc <= {mc[ACC_W-2:0], 1'b0};
      mp <= {1'b0, mp[MP_W-1:1]};
    end
  end

endmodule

FILE: design/cbst_div.sv
`timescale 1ns / 1ps
module cbst_div import cbst_pkg::*; #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dv;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, numerator shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dv  <= den;
      quo <= num;
    end else if (busy) begin
      rem <= ge ? DEN_W'(trial - {1'b0, dv}) : DEN_W'(trial);
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

FILE: design/cubic_bezier_stroke_tessellator_top.sv
`timescale 1ns / 1ps
// Cubic Bezier stroke tessellator: one input beat carries four Q12.4 control
// points and a segment count n; the block returns 2n triangle beats, two per
// segment, with tlast on the last one. All arithmetic runs on one bit-serial
// shift-add multiply unit (one multiplier bit per cycle) plus a one-bit-per-
// cycle divider for the curve parameter, and the block takes no new beat
// until the whole curve is out. Each curve point needs a divide plus 14
// multiplies with 17- or 18-bit multipliers; each segment adds multiplies for
// length and stroke terms and two ten-candidate rounding searches.
// stroke_width may be written only while the block is idle.
`include "cubic_bezier_stroke_tessellator_top_macros.svh"
module cubic_bezier_stroke_tessellator_top import cbst_pkg::*; #(
  parameter int MAX_SEGMENTS    = 32,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y,
  // segment_count, zero pad
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y
  output logic [95:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [9:0]   cfg_wdata
);

  localparam int CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int NUM_W = CW + 17;
  localparam int DEN_W = CW + 1;

  state_t state, state_next;
  op_t    op, op_next;

  logic [9:0]  stroke_width;
  logic [15:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
  logic [CW-1:0] nseg, idx;
  logic [16:0] t, u;
  logic [32:0] u2, t2;
  logic [48:0] b0, b3, c1, c2;
  logic [15:0] curx, cury, prevx, prevy;
  logic [33:0] l2;
  logic [51:0] n2;
  logic [9:0]  q, mx, my;
  logic [3:0]  bcnt;
  logic        sel;

  mul_req_t         mreq;
  logic             mul_busy, mul_done;
  logic [ACC_W-1:0] acc;
  logic             div_start, div_done;
  logic [NUM_W-1:0] quo;

  logic [5:0]  seg_in;
  logic [ACC_W-1:0] rsum;
  logic [15:0] rnd;
  logic signed [16:0] dx, dy;
  logic [16:0] adx, ady, amag;
  logic [9:0]  cand, kval;
  logic        cand_ok;
  logic signed [17:0] ox, oy;
  logic [15:0] l1x, l1y, r1x, r1y, l2x, l2y, r2x, r2y;
  logic        out_free, out_load;
  logic        in_acc, last_seg;

  cbst_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .busy (mul_busy),
    .done (mul_done),
    .acc  (acc)
  );

  cbst_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({idx, 17'b0} + NUM_W'(nseg)),
    .den   ({nseg, 1'b0}),
    .done  (div_done),
    .quo   (quo)
  );

  assign seg_in   = s_tdata[133:128];
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign last_seg = idx == nseg;

  // weighted sum rounded to nearest, ties up
  assign rsum = acc + (ACC_W'(1) << 47);
  assign rnd  = rsum[63:48];

  assign dx   = $signed({curx[15], curx}) - $signed({prevx[15], prevx});
  assign dy   = $signed({cury[15], cury}) - $signed({prevy[15], prevy});
  assign adx  = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady  = dy[16] ? 17'(-dy) : 17'(dy);
  assign amag = sel ? adx : ady;

  assign cand    = q | (10'(1) << (bcnt - 4'd1));
  assign cand_ok = cand <= 10'd512;
  assign kval    = 10'({cand, 1'b0} - 11'd1);

  assign ox = (dy > 17'sd0) ? -$signed({8'b0, mx}) : $signed({8'b0, mx});
  assign oy = (dx < 17'sd0) ? -$signed({8'b0, my}) : $signed({8'b0, my});
  assign l1x = sat16($signed({{2{prevx[15]}}, prevx}) + ox);
  assign l1y = sat16($signed({{2{prevy[15]}}, prevy}) + oy);
  assign r1x = sat16($signed({{2{prevx[15]}}, prevx}) - ox);
  assign r1y = sat16($signed({{2{prevy[15]}}, prevy}) - oy);
  assign l2x = sat16($signed({{2{curx[15]}}, curx}) + ox);
  assign l2y = sat16($signed({{2{cury[15]}}, cury}) + oy);
  assign r2x = sat16($signed({{2{curx[15]}}, curx}) - ox);
  assign r2y = sat16($signed({{2{cury[15]}}, cury}) - oy);

  function automatic logic [MP_W-1:0] ext18(input logic [15:0] v);
    return MP_W'({{2{v[15]}}, v});
  endfunction

  function automatic logic [MP_W-1:0] tri18(input logic [15:0] v);
    logic [17:0] e;
    e = {{2{v[15]}}, v};
    return MP_W'(e + {e[16:0], 1'b0});
  endfunction

  // multiply unit request for the current operation
  always_comb begin
    mreq        = '0;
    mreq.start  = state == S_MUL;
    mreq.nbits  = CNT_W'(17);
    case (op)
      OP_U2: begin mreq.clear = 1'b1; mreq.mcand = ACC_W'(u);  mreq.mplier = MP_W'(u); end
      OP_B0: begin mreq.clear = 1'b1; mreq.mcand = ACC_W'(u2); mreq.mplier = MP_W'(u); end
      OP_C1: begin mreq.clear = 1'b1; mreq.mcand = ACC_W'(u2); mreq.mplier = MP_W'(t); end
      OP_T2: begin mreq.clear = 1'b1; mreq.mcand = ACC_W'(t);  mreq.mplier = MP_W'(t); end
      OP_B3: begin mreq.clear = 1'b1; mreq.mcand = ACC_W'(t2); mreq.mplier = MP_W'(t); end
      OP_C2: begin mreq.clear = 1'b1; mreq.mcand = ACC_W'(t2); mreq.mplier = MP_W'(u); end
      OP_X0, OP_Y0: begin
        mreq.clear  = 1'b1;
        mreq.sgn    = 1'b1;
        mreq.nbits  = CNT_W'(18);
        mreq.mcand  = ACC_W'(b0);
        mreq.mplier = (op == OP_X0) ? ext18(p0x) : ext18(p0y);
      end
      OP_X1, OP_Y1: begin
        mreq.sgn    = 1'b1;
        mreq.nbits  = CNT_W'(18);
        mreq.mcand  = ACC_W'(c1);
        mreq.mplier = (op == OP_X1) ? tri18(p1x) : tri18(p1y);
      end
      OP_X2, OP_Y2: begin
        mreq.sgn    = 1'b1;
        mreq.nbits  = CNT_W'(18);
        mreq.mcand  = ACC_W'(c2);
        mreq.mplier = (op == OP_X2) ? tri18(p2x) : tri18(p2y);
      end
      OP_X3, OP_Y3: begin
        mreq.sgn    = 1'b1;
        mreq.nbits  = CNT_W'(18);
        mreq.mcand  = ACC_W'(b3);
        mreq.mplier = (op == OP_X3) ? ext18(p3x) : ext18(p3y);
      end
      OP_L2X: begin mreq.clear = 1'b1; mreq.mcand = ACC_W'(adx); mreq.mplier = MP_W'(adx); end
      OP_L2Y: begin mreq.mcand = ACC_W'(ady); mreq.mplier = MP_W'(ady); end
      OP_NW: begin
        mreq.clear  = 1'b1;
        mreq.nbits  = CNT_W'(10);
        mreq.mcand  = ACC_W'(amag);
        mreq.mplier = MP_W'(stroke_width);
      end
      OP_NN: begin
        mreq.clear  = 1'b1;
        mreq.nbits  = CNT_W'(26);
        mreq.mcand  = ACC_W'(acc[25:0]);
        mreq.mplier = acc[25:0];
      end
      OP_KL: begin
        mreq.clear  = 1'b1;
        mreq.nbits  = CNT_W'(10);
        mreq.mcand  = ACC_W'(l2);
        mreq.mplier = MP_W'(kval);
      end
      OP_KK: begin
        mreq.clear  = 1'b1;
        mreq.nbits  = CNT_W'(10);
        mreq.mcand  = ACC_W'(acc[43:0]);
        mreq.mplier = MP_W'(kval);
      end
      default: begin
        mreq.clear = 1'b1;
      end
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = state == S_IDLE;
    div_start = state == S_DIV;
    out_load  = (state == S_EMIT0 || state == S_EMIT1) && out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    op_next    = op;
    case (state)
      S_IDLE: begin
        if (in_acc) state_next = S_DIV;
      end
      S_DIV: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          op_next    = OP_U2;
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mul_done) begin
          case (op)
            OP_Y3: begin
              if (idx == '0) begin
                state_next = S_DIV;
              end else begin
                op_next    = OP_L2X;
                state_next = S_MUL;
              end
            end
            OP_L2Y: begin
              if (acc == '0) begin
                state_next = S_EMIT0;
              end else begin
                op_next    = OP_NW;
                state_next = S_MUL;
              end
            end
            OP_NN, OP_KK: state_next = S_SRCH;
            default: begin
              op_next    = op_t'(op + 5'd1);
              state_next = S_MUL;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (bcnt == 4'd0) begin
          if (!sel) begin
            op_next    = OP_NW;
            state_next = S_MUL;
          end else begin
            state_next = S_EMIT0;
          end
        end else if (cand_ok) begin
          op_next    = OP_KL;
          state_next = S_MUL;
        end
      end
      S_EMIT0: begin
        if (out_free) state_next = S_EMIT1;
      end
      S_EMIT1: begin
        if (out_free) state_next = last_seg ? S_IDLE : S_DIV;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_U2;
      stroke_width <= 10'(1 << COORD_FRAC_BITS);
      m_tvalid     <= 1'b0;
      idx          <= '0;
      nseg         <= CW'(1);
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cfg_we) stroke_width <= cfg_wdata;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_acc) begin
        idx <= '0;
        if (seg_in == 6'd0) begin
          nseg <= CW'(1);
        end else if (int'(seg_in) > MAX_SEGMENTS) begin
          nseg <= CW'(MAX_SEGMENTS);
        end else begin
          nseg <= CW'(seg_in);
        end
      end else if (state == S_MUL_WAIT && mul_done && op == OP_Y3 && idx == '0) begin
        idx <= CW'(1);
      end else if (state == S_EMIT1 && out_free && !last_seg) begin
        idx <= idx + CW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p0x <= s_tdata[15:0];    p0y <= s_tdata[31:16];
      p1x <= s_tdata[47:32];   p1y <= s_tdata[63:48];
      p2x <= s_tdata[79:64];   p2y <= s_tdata[95:80];
      p3x <= s_tdata[111:96];  p3y <= s_tdata[127:112];
    end
    if (state == S_DIV_WAIT && div_done) begin
      t <= quo[16:0];
      u <= 17'(T_ONE) - quo[16:0];
    end
    if (state == S_MUL_WAIT && mul_done) begin
      case (op)
        OP_U2: u2 <= acc[32:0];
        OP_B0: b0 <= acc[48:0];
        OP_C1: c1 <= acc[48:0];
        OP_T2: t2 <= acc[32:0];
        OP_B3: b3 <= acc[48:0];
        OP_C2: c2 <= acc[48:0];
        OP_X3: curx <= rnd;
        OP_Y3: begin
          cury <= rnd;
          if (idx == '0) begin
            prevx <= curx;
            prevy <= rnd;
          end
        end
        OP_L2Y: begin
          l2   <= acc[33:0];
          mx   <= '0;
          my   <= '0;
          sel  <= 1'b0;
          q    <= '0;
          bcnt <= 4'd10;
        end
        OP_NN: n2 <= acc[51:0];
        OP_KK: begin
          // largest candidate whose rounding bound still fits
          if ({14'b0, n2} >= acc) q <= cand;
          bcnt <= bcnt - 4'd1;
        end
        default: begin
        end
      endcase
    end
    if (state == S_SRCH) begin
      if (bcnt == 4'd0) begin
        if (!sel) begin
          mx   <= q;
          sel  <= 1'b1;
          q    <= '0;
          bcnt <= 4'd10;
        end else begin
          my <= q;
        end
      end else if (!cand_ok) begin
        bcnt <= bcnt - 4'd1;
      end
    end
    if (out_load) begin
      if (state == S_EMIT0) begin
        m_tdata <= {l2y, l2x, r1y, r1x, l1y, l1x};
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= {l2y, l2x, r2y, r2x, r1y, r1x};
        m_tlast <= last_seg;
        prevx   <= curx;
        prevy   <= cury;
      end
    end
  end

  `CBST_ASSERT_IMP(a_mul_start_idle, mreq.start, !mul_busy, "multiply started while busy")
  `CBST_ASSERT_NXT(a_accept_div, in_acc, state == S_DIV, "accepted beat did not start divide")
  `CBST_ASSERT_IMP(a_idx_range, state != S_IDLE, idx <= nseg, "point index past segment count")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [95:0] verts;
    logic        last;
  } tri_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;
  logic         m_tlast;
  logic         cfg_we;
  logic [9:0]   cfg_wdata;

  logic [135:0] curve_q[$];
  tri_t         tri_q[$];
  logic [9:0]   width_model;
  int           err_cnt;
  bit           took;
  bit           quiet;
  int           src_gap;
  int           sink_gap;
  int           sink_hold;
  string        vert_names[6] = '{"vert_a_x", "vert_a_y", "vert_b_x",
                                  "vert_b_y", "vert_c_x", "vert_c_y"};

  cubic_bezier_stroke_tessellator_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // bernstein sum at t (16 fraction bits), rounded to nearest q12.4
  function automatic longint curve_pt(input longint p0, p1, p2, p3, input longint t);
    longint u, w0, w1, w2, w3, s;
    u = 65536 - t;
    w0 = u * u * u;
    w1 = 3 * u * u * t;
    w2 = 3 * u * t * t;
    w3 = t * t * t;
    s = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3;
    s = (s + (longint'(1) <<< 47)) >>> 48;
    return clamp16(s);
  endfunction

  // round(a * w / (2 len)) by search over the rounding boundary
  function automatic longint perp_mag(input longint a, input longint l2, input longint w);
    logic [127:0] n2, k, c, q;
    q = 0;
    n2 = 128'(a * w) * 128'(a * w);
    for (int b = 512; b != 0; b = b >> 1) begin
      c = q | 128'(b);
      k = 2 * c - 1;
      if (c <= 512 && n2 >= k * k * 128'(l2)) q = c;
    end
    return longint'(q);
  endfunction

  task automatic predict_strip(input logic [135:0] item);
    longint cx[4], cy[4];
    longint px[33], py[33];
    longint n, t, dx, dy, l2, ox, oy;
    longint l1x, l1y, r1x, r1y, l2x, l2y, r2x, r2y;
    tri_t e;
    for (int k = 0; k < 4; k++) begin
      cx[k] = longint'($signed(item[32*k +: 16]));
      cy[k] = longint'($signed(item[32*k+16 +: 16]));
    end
    n = longint'(item[128 +: 6]);
    if (n == 0) n = 1;
    if (n > 32) n = 32;
    for (int i = 0; i <= n; i++) begin
      t = (i * 131072 + n) / (2 * n);
      px[i] = curve_pt(cx[0], cx[1], cx[2], cx[3], t);
      py[i] = curve_pt(cy[0], cy[1], cy[2], cy[3], t);
    end
    for (int i = 0; i < n; i++) begin
      dx = px[i+1] - px[i];
      dy = py[i+1] - py[i];
      l2 = dx * dx + dy * dy;
      ox = 0;
      oy = 0;
      if (l2 != 0) begin
        ox = perp_mag(dy < 0 ? -dy : dy, l2, longint'(width_model));
        oy = perp_mag(dx < 0 ? -dx : dx, l2, longint'(width_model));
        if (dy > 0) ox = -ox;
        if (dx < 0) oy = -oy;
      end
      l1x = clamp16(px[i] + ox);   l1y = clamp16(py[i] + oy);
      r1x = clamp16(px[i] - ox);   r1y = clamp16(py[i] - oy);
      l2x = clamp16(px[i+1] + ox); l2y = clamp16(py[i+1] + oy);
      r2x = clamp16(px[i+1] - ox); r2y = clamp16(py[i+1] - oy);
      e.verts = {l2y[15:0], l2x[15:0], r1y[15:0], r1x[15:0], l1y[15:0], l1x[15:0]};
      e.last = 0;
      tri_q = {tri_q, e};
      e.verts = {l2y[15:0], l2x[15:0], r2y[15:0], r2x[15:0], r1y[15:0], r1x[15:0]};
      e.last = (i + 1 == n);
      tri_q = {tri_q, e};
    end
  endtask

  task automatic report(input string what, input logic [95:0] got, input logic [95:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // input side: predict on each accepted beat
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_strip(s_tdata);
      took = 1;
    end
  end

  // driver
  always @(negedge clk) begin
    logic v;
    logic [135:0] d;
    v = s_tvalid;
    d = s_tdata;
    if (rst) begin
      v = 0;
    end else if (!s_tvalid || took) begin
      took = 0;
      v = 0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (curve_q.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(1, 17);
      end else if (curve_q.size() != 0) begin
        d = curve_q.pop_front();
        v = 1;
      end
    end
    s_tvalid <= v;
    s_tdata <= d;
  end

  // output side
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      m_tready <= 0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 17);
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    tri_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (tri_q.size() == 0) begin
        report("unexpected beat", m_tdata, '0);
      end else begin
        e = tri_q.pop_front();
        for (int f = 0; f < 6; f++) begin
          if (m_tdata[16*f +: 16] !== e.verts[16*f +: 16])
            report(vert_names[f], 96'(m_tdata[16*f +: 16]), 96'(e.verts[16*f +: 16]));
        end
        if (m_tlast !== e.last) report("final_triangle", 96'(m_tlast), 96'(e.last));
      end
    end
  end

  function automatic logic [135:0] make_curve(input logic [15:0] x0, y0, x1, y1, x2, y2,
                                              x3, y3, input logic [5:0] n);
    return {2'b0, n, y3, x3, y2, x2, y1, x1, y0, x0};
  endfunction

  function automatic logic [15:0] rand_coord(input int mode, input logic [15:0] base);
    case (mode)
      0: return 16'($urandom);
      1: return base + 16'($urandom_range(0, 255)) - 16'd128;
      2: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 40))
                                      : 16'h8000 + 16'($urandom_range(0, 40));
      default: return base;
    endcase
  endfunction

  task automatic queue_curve(input logic [135:0] item);
    curve_q = {curve_q, item};
  endtask

  task automatic add_random_curve();
    logic [15:0] c[8];
    logic [15:0] bx, by;
    logic [5:0] n;
    int mode;
    mode = $urandom_range(0, 9);
    mode = mode < 4 ? 0 : (mode < 8 ? 1 : (mode < 9 ? 2 : 3));
    bx = 16'($urandom);
    by = 16'($urandom);
    for (int k = 0; k < 4; k++) begin
      c[2*k] = rand_coord(mode, bx);
      c[2*k+1] = rand_coord(mode, by);
    end
    // long curves are slow; keep them rare
    n = ($urandom_range(0, 39) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 4));
    queue_curve(make_curve(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], n));
  endtask

  task automatic set_width(input logic [9:0] w);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 0;
    width_model = w;
  endtask

  task automatic drain();
    while (curve_q.size() != 0 || s_tvalid || tri_q.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    logic [9:0] widths[7];
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    m_tready = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    err_cnt = 0;
    took = 0;
    quiet = 0;
    src_gap = 0;
    sink_gap = 0;
    sink_hold = 0;
    width_model = 10'd16;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: zero curve, extremes, coincident points, segment count edges
    queue_curve(make_curve(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 6'd1));
    queue_curve(make_curve(16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                           16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 6'd1));
    queue_curve(make_curve(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                           16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 6'd2));
    queue_curve(make_curve(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                           16'h8000, 16'h8000, 16'h8000, 16'h8000, 6'd2));
    queue_curve(make_curve(16'd100, 16'd100, 16'd100, 16'd100,
                           16'd100, 16'd100, 16'd100, 16'd100, 6'd3));
    queue_curve(make_curve(16'd0, 16'd0, 16'd160, 16'd0, 16'd320, 16'd0, 16'd480, 16'd0, 6'd0));
    queue_curve(make_curve(16'd0, 16'd0, 16'd0, 16'd160, 16'd0, 16'd320, 16'd0, 16'd480, 6'd4));
    queue_curve(make_curve(16'd480, 16'd0, 16'd320, 16'd0, 16'd160, 16'd0, 16'd0, 16'd0, 6'd2));
    queue_curve(make_curve(16'd0, 16'd480, 16'd0, 16'd320, 16'd0, 16'd160, 16'd0, 16'd0, 6'd2));
    queue_curve(make_curve(16'd0, 16'd0, 16'd500, 16'd800,
                           -16'sd300, 16'd900, 16'd40, -16'sd16, 6'd32));
    queue_curve(make_curve(16'h7ff0, 16'h8010, 16'h8000, 16'h7fff,
                           16'h7fff, 16'h8000, 16'h8010, 16'h7ff0, 6'd33));
    queue_curve(make_curve(-16'sd1000, 16'd200, 16'd3000, -16'sd4000,
                           -16'sd2000, 16'd5000, 16'd1000, 16'd0, 6'd63));
    queue_curve(make_curve(16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
                           16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 6'd5));
    queue_curve(make_curve(16'd0, 16'd0, 16'd1, 16'd1, 16'd2, 16'd2, 16'd3, 16'd3, 6'd16));
    drain();

    widths[0] = 10'd1023;
    widths[1] = 10'd0;
    widths[2] = 10'd1;
    widths[3] = 10'($urandom);
    widths[4] = 10'($urandom);
    widths[5] = 10'h2aa;
    widths[6] = 10'd16;
    for (int ph = 0; ph < 7; ph++) begin
      set_width(widths[ph]);
      if (ph == 0) begin
        queue_curve(make_curve(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
                               16'h8000, 16'h8000, 16'h8000, 16'h7fff, 6'd3));
        queue_curve(make_curve(16'h8000, 16'd0, 16'h8000, 16'd100, 16'h8000, 16'd200,
                               16'h8000, 16'd300, 6'd2));
      end
      if (ph == 6) quiet = 1;
      for (int i = 0; i < 56; i++) add_random_curve();
      // long receiver hold so the block backs up and stalls its input
      if (ph == 1) sink_hold = 3000;
      drain();
    end

    repeat (200) @(negedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #250ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
